// ===== design/rsec_pkg.sv =====
// Shared types and constants for the room sensor event classifier.
// Holds the event, configuration and state structs and the code enums.
// No dependencies.
`default_nettype none

package rsec_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned SampleW = 13;
  localparam int unsigned TempW   = 18;
  localparam int unsigned LightW  = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 88;

  localparam logic [11:0] LightThresholdRst = 12'd1500;
  localparam logic [11:0] LightChangeRst    = 12'd400;
  localparam logic [10:0] HeatThresholdRst  = 11'd810;
  localparam logic [10:0] CoolThresholdRst  = 11'd820;
  localparam logic [9:0]  HumidityLowRst    = 10'd300;
  localparam logic [9:0]  HumidityHighRst   = 10'd550;
  localparam logic [31:0] OccTimeoutRst     = 32'd120000;

  typedef enum logic [1:0] {
    ACT_MOTION   = 2'd0,
    ACT_LIGHT    = 2'd1,
    ACT_TEMP     = 2'd2,
    ACT_HUMIDITY = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIGHT_THRESHOLD = 3'd0,
    CFG_LIGHT_CHANGE    = 3'd1,
    CFG_HEAT_THRESHOLD  = 3'd2,
    CFG_COOL_THRESHOLD  = 3'd3,
    CFG_HUMIDITY_LOW    = 3'd4,
    CFG_HUMIDITY_HIGH   = 3'd5,
    CFG_OCC_TIMEOUT     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] light_threshold;
    logic [11:0] light_delta;
    logic [10:0] heat_threshold_f_x10;
    logic [10:0] cool_threshold_f_x10;
    logic [9:0]  humidity_low_x10;
    logic [9:0]  humidity_high_x10;
    logic [31:0] occupancy_timeout_ms;
  } cfg_t;

  typedef struct packed {
    action_e                     action;
    logic signed [SampleW-1:0]   sample_value;
    logic [TimeW-1:0]            event_time_ms;
  } event_t;

  typedef struct packed {
    logic                        occupied;
    logic [TimeW-1:0]            last_motion_ms;
    logic                        lamp_on;
    logic                        light_seen;
    logic [LightW-1:0]           previous_light;
    logic                        heating;
    logic                        cooling;
    logic                        humidifier;
    logic signed [TempW-1:0]     temp_f_x100;
    logic signed [SampleW-1:0]   humidity_x10;
  } state_t;

endpackage

`default_nettype wire

// ===== design/rsec_cfg.sv =====
// Configuration register file of the room sensor event classifier.
// Depends on rsec_pkg for the register index codes and the cfg_t struct.
`default_nettype none

module rsec_cfg import rsec_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LIGHT_THRESHOLD: cfg_d.light_threshold      = cfg_data_i[11:0];
        CFG_LIGHT_CHANGE:    cfg_d.light_delta          = cfg_data_i[11:0];
        CFG_HEAT_THRESHOLD:  cfg_d.heat_threshold_f_x10 = cfg_data_i[10:0];
        CFG_COOL_THRESHOLD:  cfg_d.cool_threshold_f_x10 = cfg_data_i[10:0];
        CFG_HUMIDITY_LOW:    cfg_d.humidity_low_x10     = cfg_data_i[9:0];
        CFG_HUMIDITY_HIGH:   cfg_d.humidity_high_x10    = cfg_data_i[9:0];
        CFG_OCC_TIMEOUT:     cfg_d.occupancy_timeout_ms = cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_threshold      <= LightThresholdRst;
      cfg_q.light_delta          <= LightChangeRst;
      cfg_q.heat_threshold_f_x10 <= HeatThresholdRst;
      cfg_q.cool_threshold_f_x10 <= CoolThresholdRst;
      cfg_q.humidity_low_x10     <= HumidityLowRst;
      cfg_q.humidity_high_x10    <= HumidityHighRst;
      cfg_q.occupancy_timeout_ms <= OccTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/rsec_core.sv =====
// Next-state logic of the room sensor event classifier for one event.
// Depends on rsec_pkg for the event, state and configuration structs.
`default_nettype none

module rsec_core import rsec_pkg::*; (
  input  wire cfg_t   cfg_i,
  input  wire state_t state_i,
  input  wire event_t event_i,
  output state_t      state_o
);

  logic                      is_motion, is_light, is_temp, is_hum;
  logic [LightW-1:0]         light_val;
  logic signed [13:0]        light_rise, light_fall, light_chg;
  logic                      light_above;
  logic signed [TempW-1:0]   samp_ext, lhs, heat_lim, cool_lim, temp_f;
  logic signed [13:0]        hum_ext, hum_low, hum_high;
  logic [TimeW-1:0]          last_next;
  logic signed [TimeW:0]     elapsed, timeout_ext;

  assign is_motion = (event_i.action == ACT_MOTION);
  assign is_light  = (event_i.action == ACT_LIGHT);
  assign is_temp   = (event_i.action == ACT_TEMP);
  assign is_hum    = (event_i.action == ACT_HUMIDITY);

  // Negative light samples saturate to zero.
  assign light_val   = event_i.sample_value[SampleW-1] ? '0 : event_i.sample_value[11:0];
  assign light_rise  = $signed({2'b00, light_val}) - $signed({2'b00, state_i.previous_light});
  assign light_fall  = $signed({2'b00, state_i.previous_light}) - $signed({2'b00, light_val});
  assign light_chg   = $signed({2'b00, cfg_i.light_delta});
  assign light_above = (light_val > cfg_i.light_threshold);

  // Fahrenheit comparisons done as 9*v against (threshold - 320)*5.
  assign samp_ext = {{(TempW-SampleW){event_i.sample_value[SampleW-1]}}, event_i.sample_value};
  assign lhs      = samp_ext * 18'sd9;
  assign heat_lim = ($signed({7'b0, cfg_i.heat_threshold_f_x10}) - 18'sd320) * 18'sd5;
  assign cool_lim = ($signed({7'b0, cfg_i.cool_threshold_f_x10}) - 18'sd320) * 18'sd5;
  assign temp_f   = samp_ext * 18'sd18 + 18'sd3200;

  assign hum_ext  = {event_i.sample_value[SampleW-1], event_i.sample_value};
  assign hum_low  = $signed({4'b0, cfg_i.humidity_low_x10});
  assign hum_high = $signed({4'b0, cfg_i.humidity_high_x10});

  // A timestamp earlier than the last motion gives a negative difference.
  assign last_next   = is_motion ? event_i.event_time_ms : state_i.last_motion_ms;
  assign elapsed     = $signed({1'b0, event_i.event_time_ms}) - $signed({1'b0, last_next});
  assign timeout_ext = $signed({17'b0, cfg_i.occupancy_timeout_ms});

  always_comb begin
    state_o = state_i;
    state_o.last_motion_ms = last_next;
    state_o.occupied = (is_motion | state_i.occupied) & ~(elapsed > timeout_ext);

    if (is_light) begin
      state_o.light_seen     = 1'b1;
      state_o.previous_light = light_val;
      if (!state_i.light_seen) begin
        state_o.lamp_on = light_above;
      end else if (!state_i.lamp_on && light_above && (light_rise > light_chg)) begin
        state_o.lamp_on = 1'b1;
      end else if (state_i.lamp_on && !light_above && (light_fall > light_chg)) begin
        state_o.lamp_on = 1'b0;
      end
    end

    if (is_temp) begin
      state_o.temp_f_x100 = temp_f;
      if ((lhs < heat_lim) && !state_i.heating) begin
        state_o.heating = 1'b1;
        state_o.cooling = 1'b0;
      end else if ((lhs > cool_lim) && !state_i.cooling) begin
        state_o.cooling = 1'b1;
        state_o.heating = 1'b0;
      end else if ((lhs >= heat_lim) && (lhs <= cool_lim)) begin
        state_o.heating = 1'b0;
        state_o.cooling = 1'b0;
      end
    end

    if (is_hum) begin
      state_o.humidity_x10 = event_i.sample_value;
      if ((hum_ext < hum_low) && !state_i.humidifier) begin
        state_o.humidifier = 1'b1;
      end else if ((hum_ext > hum_high) && state_i.humidifier) begin
        state_o.humidifier = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/room_sensor_event_classifier.sv =====
// Top level of the room sensor event classifier: stream ports, input and
// result registers and room state. Uses rsec_pkg, rsec_cfg and rsec_core.
//
//   Channel   Direction  Transfer                 Payload
//   s_axis    in         tvalid & tready          event (action in tuser)
//   m_axis    out        tvalid & tready          status
//   cfg       in         cfg_we_i                 register index and data
//
// One event per cycle sustained while m_axis_tready is high. The input
// register feeds the state update and the result register combinationally;
// the result is offered once loaded, and the state loads together with it.
// Reset clears both valid flags and room state and restores the cfg registers.
// A stalled result holds while the input register can still take one more event.
`default_nettype none

module room_sensor_event_classifier import rsec_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  // Event stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: sample_value[12:0], event_time_ms[60:13], zeros above
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // tuser: action[1:0]
  input  wire logic [1:0]          s_axis_tuser,
  // Status stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: occupied[0], lamp_on[1], temp_f_x100[19:2], humidity_x10[32:20],
  // heat_req[33], cool_req[34], humid_req[35],
  // update_time_ms[83:36], zeros above
  output logic [OutDataW-1:0]      m_axis_tdata
);

  cfg_t   cfg;
  event_t in_event_q;
  logic   in_valid_q;
  state_t state_q, state_d;
  logic   out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic   advance;

  rsec_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rsec_core u_core (
    .cfg_i   (cfg),
    .state_i (state_q),
    .event_i (in_event_q),
    .state_o (state_d)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign out_data_d = {4'b0,
                       in_event_q.event_time_ms,
                       state_d.humidifier,
                       state_d.cooling,
                       state_d.heating,
                       state_d.humidity_x10,
                       state_d.temp_f_x100,
                       state_d.lamp_on,
                       state_d.occupied};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_event_q.action        <= action_e'(s_axis_tuser);
      in_event_q.sample_value  <= s_axis_tdata[SampleW-1:0];
      in_event_q.event_time_ms <= s_axis_tdata[SampleW+TimeW-1:SampleW];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
